### rtl/aiu_pkg.sv
// ----------------------------------------------------------------------------
// Alphabet index unpacker package
// Shared constants, the front-to-back queue entry and the symbol width rule.
// ----------------------------------------------------------------------------
package aiu_pkg;

  localparam int unsigned AlphabetDepthDefault = 128;
  localparam int unsigned ByteW                = 8;
  localparam int unsigned TotalW               = 16;
  localparam int unsigned NumW                 = 16;
  localparam int unsigned BufW                 = 15;
  localparam int unsigned CntW                 = 4;
  localparam int unsigned WidthW               = 3;
  localparam int unsigned IdxW                 = 7;
  localparam int unsigned QueueDepth           = 4;

  // One entry per header or packed-data byte, in arrival order.
  typedef struct packed {
    logic             is_header;
    logic [ByteW-1:0] data;
  } q_entry_t;

  // Smallest width of 1 to 7 bits whose range covers the alphabet size; sizes above 128 also get width 7.
  function automatic logic [WidthW-1:0] symbol_width_f(input logic [ByteW-1:0] size);
    logic [WidthW-1:0] w;
    if (size <= 8'd2) begin
      w = 3'd1;
    end else if (size <= 8'd4) begin
      w = 3'd2;
    end else if (size <= 8'd8) begin
      w = 3'd3;
    end else if (size <= 8'd16) begin
      w = 3'd4;
    end else if (size <= 8'd32) begin
      w = 3'd5;
    end else if (size <= 8'd64) begin
      w = 3'd6;
    end else begin
      w = 3'd7;
    end
    return w;
  endfunction

endpackage

### rtl/aiu_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module aiu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/aiu_queue.sv
// ----------------------------------------------------------------------------
// Front-to-back queue
// Small register FIFO that decouples byte classification from unpacking.
// ----------------------------------------------------------------------------
module aiu_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  aiu_pkg::q_entry_t push_entry_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output aiu_pkg::q_entry_t pop_entry_o,
  output logic              empty_o
);

  localparam int unsigned PtrW = $clog2(aiu_pkg::QueueDepth);
  localparam int unsigned FillW = $clog2(aiu_pkg::QueueDepth + 1);

  aiu_pkg::q_entry_t entries_q [aiu_pkg::QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FillW-1:0]  fill_q, fill_d;
  logic              push, pop;

  assign push_ready_o = (fill_q != FillW'(aiu_pkg::QueueDepth));
  assign pop_valid_o  = (fill_q != '0);
  assign empty_o      = (fill_q == '0);
  assign pop_entry_o  = entries_q[rd_ptr_q];

  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? PtrW'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = pop ? PtrW'(rd_ptr_q + 1'b1) : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !pop) begin
      fill_d = FillW'(fill_q + 1'b1);
    end else if (pop && !push) begin
      fill_d = FillW'(fill_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

### rtl/aiu_front.sv
// ----------------------------------------------------------------------------
// Unpacker front end
// Classifies input bytes, fills the alphabet RAM and queues header and data.
// ----------------------------------------------------------------------------
module aiu_front #(
  parameter int unsigned ALPHABET_DEPTH = aiu_pkg::AlphabetDepthDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [aiu_pkg::ByteW-1:0]         in_byte_i,
  input  logic                              in_start_i,
  input  logic                              drained_i,
  output logic                              push_valid_o,
  input  logic                              push_ready_i,
  output aiu_pkg::q_entry_t                 push_entry_o,
  output logic                              ram_we_o,
  output logic [$clog2(ALPHABET_DEPTH)-1:0] ram_waddr_o,
  output logic [aiu_pkg::ByteW-1:0]         ram_wdata_o
);

  localparam int unsigned AddrW = $clog2(ALPHABET_DEPTH);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_ALPHA,
    PH_DATA
  } phase_e;

  phase_e                    phase_q, phase_d;
  logic [aiu_pkg::ByteW-1:0] size_q, size_d;
  logic [aiu_pkg::ByteW-1:0] fill_q, fill_d;
  logic [aiu_pkg::ByteW-1:0] fill_inc;
  logic                      accept, is_header;

  // Alphabet writes wait until every older symbol has read the RAM.
  assign in_ready_o = push_ready_i && ((phase_q != PH_ALPHA) || drained_i);
  assign accept     = in_valid_i && in_ready_o;
  assign is_header  = in_start_i || (phase_q == PH_HEADER);
  assign fill_inc   = fill_q + 8'd1;

  assign push_valid_o           = accept && (is_header || (phase_q == PH_DATA));
  assign push_entry_o.is_header = is_header;
  assign push_entry_o.data      = in_byte_i;

  assign ram_we_o    = accept && !is_header && (phase_q == PH_ALPHA) &&
                       (fill_q < aiu_pkg::ByteW'(ALPHABET_DEPTH));
  assign ram_waddr_o = fill_q[AddrW-1:0];
  assign ram_wdata_o = in_byte_i;

  always_comb begin
    phase_d = phase_q;
    size_d  = size_q;
    fill_d  = fill_q;
    if (accept) begin
      if (is_header) begin
        size_d  = in_byte_i;
        fill_d  = '0;
        phase_d = (in_byte_i == '0) ? PH_DATA : PH_ALPHA;
      end else begin
        unique case (phase_q)
          PH_ALPHA: begin
            fill_d = fill_inc;
            if (fill_inc >= size_q) begin
              phase_d = PH_DATA;
            end
          end
          PH_DATA:   phase_d = PH_DATA;
          default:   phase_d = PH_HEADER;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      size_q  <= '0;
      fill_q  <= '0;
    end else begin
      phase_q <= phase_d;
      size_q  <= size_d;
      fill_q  <= fill_d;
    end
  end

endmodule

### rtl/aiu_back.sv
// ----------------------------------------------------------------------------
// Unpacker back end
// Slices queued data bytes into indices, looks them up and registers results.
// ----------------------------------------------------------------------------
module aiu_back #(
  parameter int unsigned ALPHABET_DEPTH = aiu_pkg::AlphabetDepthDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [aiu_pkg::TotalW-1:0]        total_bits_i,
  input  logic                              pop_valid_i,
  output logic                              pop_ready_o,
  input  aiu_pkg::q_entry_t                 pop_entry_i,
  output logic                              busy_o,
  output logic                              ram_re_o,
  output logic [$clog2(ALPHABET_DEPTH)-1:0] ram_raddr_o,
  input  logic [aiu_pkg::ByteW-1:0]         ram_rdata_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [aiu_pkg::ByteW-1:0]         out_symbol_o,
  output logic [aiu_pkg::NumW-1:0]          out_number_o,
  output logic                              out_last_o,
  output logic                              out_done_o
);

  localparam int unsigned AddrW = $clog2(ALPHABET_DEPTH);

  // Unpack stage state.
  logic [aiu_pkg::WidthW-1:0] width_q, width_d;
  logic [aiu_pkg::ByteW-1:0]  size_q, size_d;
  logic [aiu_pkg::BufW-1:0]   buf_q, buf_d, buf1;
  logic [aiu_pkg::CntW-1:0]   cnt_q, cnt_d, cnt1;
  logic [aiu_pkg::TotalW-1:0] pos_q, pos_d, pos1;
  logic [aiu_pkg::NumW-1:0]   num_q, num_d, num1;
  logic                       done_q, done_d, done1;

  // Result stage.
  logic                       b_valid_q;
  logic [aiu_pkg::NumW-1:0]   b_num_q;
  logic                       b_last_q, b_done_q, b_hit_q;

  logic [aiu_pkg::CntW-1:0]   w_ext, cnt_left;
  logic [aiu_pkg::ByteW-1:0]  mask;
  logic [aiu_pkg::IdxW-1:0]   idx;
  logic [aiu_pkg::TotalW:0]   pos_sum;
  logic [aiu_pkg::TotalW-1:0] pos_next;
  logic                       pend, b_can, emit, take;
  logic                       sym_done, sym_last, hit;

  assign w_ext    = aiu_pkg::CntW'(width_q);
  assign pend     = (cnt_q >= w_ext) && !done_q;
  assign b_can    = !b_valid_q || out_ready_i;
  assign emit     = pend && b_can;

  assign mask     = (8'd1 << width_q) - 8'd1;
  assign idx      = buf_q[aiu_pkg::IdxW-1:0] & mask[aiu_pkg::IdxW-1:0];
  assign hit      = ({1'b0, idx} < size_q) &&
                    ({1'b0, idx} < aiu_pkg::ByteW'(ALPHABET_DEPTH));
  assign pos_sum  = {1'b0, pos_q} + (aiu_pkg::TotalW + 1)'(width_q);
  assign pos_next = pos_sum[aiu_pkg::TotalW] ? '1 : pos_sum[aiu_pkg::TotalW-1:0];
  assign sym_done = (pos_next >= total_bits_i);
  assign cnt_left = cnt_q - w_ext;
  assign sym_last = sym_done || (cnt_left < w_ext);

  assign ram_re_o    = emit;
  assign ram_raddr_o = idx[AddrW-1:0];

  // State after this cycle's symbol, so a new byte can merge in the same cycle.
  always_comb begin
    buf1  = buf_q;
    cnt1  = cnt_q;
    pos1  = pos_q;
    num1  = num_q;
    done1 = done_q;
    if (emit) begin
      buf1  = buf_q >> width_q;
      cnt1  = cnt_left;
      pos1  = pos_next;
      num1  = num_q + 16'd1;
      done1 = done_q || sym_done;
    end
  end

  assign take        = pop_valid_i && !((cnt1 >= w_ext) && !done1);
  assign pop_ready_o = take;
  assign busy_o      = pend;

  always_comb begin
    width_d = width_q;
    size_d  = size_q;
    buf_d   = buf1;
    cnt_d   = cnt1;
    pos_d   = pos1;
    num_d   = num1;
    done_d  = done1;
    if (take) begin
      if (pop_entry_i.is_header) begin
        size_d  = pop_entry_i.data;
        width_d = aiu_pkg::symbol_width_f(pop_entry_i.data);
        buf_d   = '0;
        cnt_d   = '0;
        pos_d   = '0;
        num_d   = '0;
        done_d  = 1'b0;
      end else if (done1 || (pos1 >= total_bits_i)) begin
        done_d = 1'b1;
      end else begin
        buf_d = buf1 | (aiu_pkg::BufW'(pop_entry_i.data) << cnt1);
        cnt_d = cnt1 + 4'd8;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= 3'd1;
      size_q    <= '0;
      buf_q     <= '0;
      cnt_q     <= '0;
      pos_q     <= '0;
      num_q     <= '0;
      done_q    <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      width_q <= width_d;
      size_q  <= size_d;
      buf_q   <= buf_d;
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
      num_q   <= num_d;
      done_q  <= done_d;
      if (b_can) begin
        b_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      b_num_q  <= num_q;
      b_last_q <= sym_last;
      b_done_q <= sym_done;
      b_hit_q  <= hit;
    end
  end

  assign out_valid_o  = b_valid_q;
  assign out_symbol_o = b_hit_q ? ram_rdata_i : '0;
  assign out_number_o = b_num_q;
  assign out_last_o   = b_last_q;
  assign out_done_o   = b_done_q;

endmodule

### rtl/alphabet_index_unpacker_core.sv
// ----------------------------------------------------------------------------
// Alphabet index unpacker core
// Decodes a header, an alphabet and packed fixed-width indices into characters.
// ----------------------------------------------------------------------------
// Usage: bytes enter on the s_axis channel, one per transfer; tuser set marks
// the first byte of a message (the alphabet size). The first byte after reset
// is also taken as a header. Alphabet bytes follow, then packed data.
// Each decoded character leaves on m_axis with its position in tdata, tlast
// on the last symbol a byte produced and tuser on the final symbol.
// total_bits is written on the cfg channel; the user must do so only while the
// core is idle, which the core itself does not enforce. Throughput: a data byte
// stays in the unpack stage until the symbols it yields (up to eight at width
// one) are emitted; the result channel carries one symbol per cycle while
// m_axis is not stalled. Each alphabet byte waits until all queued symbols have
// read the alphabet RAM, so that no entry still being looked up is overwritten.
// A data byte goes through the queue, the unpack stage and the result stage.
// A four-entry queue lets input transfers continue while m_axis is stalled.
// Reset clears all control state; the alphabet RAM is not cleared.
// ----------------------------------------------------------------------------
module alphabet_index_unpacker_core #(
  parameter int unsigned ALPHABET_DEPTH = aiu_pkg::AlphabetDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_wdata_i,     // total_bits
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // [7:0] encoded_byte
  input  logic        s_axis_tuser,    // [0] message_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,    // [7:0] symbol, [23:8] symbol_number
  output logic        m_axis_tlast,    // last_in_run
  output logic        m_axis_tuser     // [0] message_done
);

  localparam int unsigned AddrW = $clog2(ALPHABET_DEPTH);

  logic [aiu_pkg::TotalW-1:0] total_bits_q;
  logic                       push_valid, push_ready, pop_valid, pop_ready, q_empty;
  aiu_pkg::q_entry_t          push_entry, pop_entry;
  logic                       back_busy, drained;
  logic                       ram_we, ram_re;
  logic [AddrW-1:0]           ram_waddr, ram_raddr;
  logic [aiu_pkg::ByteW-1:0]  ram_wdata, ram_rdata;
  logic [aiu_pkg::ByteW-1:0]  out_symbol;
  logic [aiu_pkg::NumW-1:0]   out_number;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_bits_q <= '0;
    end else if (cfg_valid_i) begin
      total_bits_q <= cfg_wdata_i;
    end
  end

  assign drained = q_empty && !back_busy;

  aiu_front #(
    .ALPHABET_DEPTH(ALPHABET_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .in_start_i   (s_axis_tuser),
    .drained_i    (drained),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata)
  );

  aiu_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry),
    .empty_o      (q_empty)
  );

  aiu_ram #(
    .WIDTH(aiu_pkg::ByteW),
    .DEPTH(ALPHABET_DEPTH)
  ) u_alpha_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  aiu_back #(
    .ALPHABET_DEPTH(ALPHABET_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .total_bits_i (total_bits_q),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_entry_i  (pop_entry),
    .busy_o       (back_busy),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_symbol_o (out_symbol),
    .out_number_o (out_number),
    .out_last_o   (m_axis_tlast),
    .out_done_o   (m_axis_tuser)
  );

  assign m_axis_tdata = {out_number, out_symbol};

  // An alphabet write must never race a pending lookup of older data.
  a_ram_write_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (q_empty && !back_busy))
    else $error("alphabet write while lookups are pending");

  // The final symbol of a message always ends its run.
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("message done without end of run");

  // A lookup is only issued when the result stage can take it.
  a_read_has_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_re && m_axis_tvalid) |-> m_axis_tready)
    else $error("lookup issued into a stalled result stage");

endmodule
